FILE: src/qts_pkg.sv
package qts_pkg;

    localparam int MAX_TEXT_DEF = 512;
    localparam int KEYWORD_CHARS_DEF = 7;
    localparam int TEXT_W = 10;
    localparam logic [32:0] ACC_SAT = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        M_START   = 3'd0,
        M_IDENT   = 3'd1,
        M_NUMBER  = 3'd2,
        M_DECIMAL = 3'd3,
        M_STRING  = 3'd4
    } scan_mode_t;

    localparam logic [3:0] K_TEXT    = 4'd0;
    localparam logic [3:0] K_SEMI    = 4'd1;
    localparam logic [3:0] K_LBRACK  = 4'd2;
    localparam logic [3:0] K_RBRACK  = 4'd3;
    localparam logic [3:0] K_LBRACE  = 4'd4;
    localparam logic [3:0] K_RBRACE  = 4'd5;
    localparam logic [3:0] K_LPAREN  = 4'd6;
    localparam logic [3:0] K_RPAREN  = 4'd7;
    localparam logic [3:0] K_COMMA   = 4'd8;
    localparam logic [3:0] K_IDENT   = 4'd9;
    localparam logic [3:0] K_STRING  = 4'd10;
    localparam logic [3:0] K_INT     = 4'd11;
    localparam logic [3:0] K_DECIMAL = 4'd12;
    localparam logic [3:0] K_TYPEKW  = 4'd13;
    localparam logic [3:0] K_OPCODE  = 4'd14;
    localparam logic [3:0] K_ERROR   = 4'd15;

    localparam logic [1:0] E_UNEXPECTED = 2'd0;
    localparam logic [1:0] E_TOO_LONG   = 2'd1;
    localparam logic [1:0] E_NO_OPCODE  = 2'd2;
    localparam logic [1:0] E_BAD_NUMBER = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  ch;
        logic [9:0]  len;
        logic [4:0]  kw;
        logic [31:0] val;
        logic [4:0]  scale;
        logic [1:0]  err;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic       is_op;
        logic [4:0] index;
    } kw_hit_t;

    localparam int N_TYPE = 27;
    localparam int N_OP = 14;

    // keywords packed left-aligned in 8 bytes, length alongside
    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] txt;
    } kw_entry_t;

    function automatic kw_entry_t type_kw(input int i);
        kw_entry_t e;
        e = '0;
        case (i)
            0:  e = '{4'd6, {"struct", 16'h0}};
            1:  e = '{4'd5, {"union", 24'h0}};
            2:  e = '{4'd4, {"enum", 32'h0}};
            3:  e = '{4'd2, {"u8", 48'h0}};
            4:  e = '{4'd3, {"u16", 40'h0}};
            5:  e = '{4'd3, {"u32", 40'h0}};
            6:  e = '{4'd3, {"u64", 40'h0}};
            7:  e = '{4'd2, {"i8", 48'h0}};
            8:  e = '{4'd3, {"i16", 40'h0}};
            9:  e = '{4'd3, {"i32", 40'h0}};
            10: e = '{4'd3, {"i64", 40'h0}};
            11: e = '{4'd3, {"f16", 40'h0}};
            12: e = '{4'd3, {"f32", 40'h0}};
            13: e = '{4'd3, {"f64", 40'h0}};
            14: e = '{4'd4, {"f128", 32'h0}};
            15: e = '{4'd4, {"cf32", 32'h0}};
            16: e = '{4'd4, {"cf64", 32'h0}};
            17: e = '{4'd5, {"cf128", 24'h0}};
            18: e = '{4'd5, {"cf256", 24'h0}};
            19: e = '{4'd4, {"ci16", 32'h0}};
            20: e = '{4'd4, {"ci32", 32'h0}};
            21: e = '{4'd4, {"ci64", 32'h0}};
            22: e = '{4'd5, {"ci128", 24'h0}};
            23: e = '{4'd4, {"cu16", 32'h0}};
            24: e = '{4'd4, {"cu32", 32'h0}};
            25: e = '{4'd4, {"cu64", 32'h0}};
            26: e = '{4'd5, {"cu128", 24'h0}};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic kw_entry_t op_kw(input int i);
        kw_entry_t e;
        e = '0;
        case (i)
            0:  e = '{4'd6, {"create", 16'h0}};
            1:  e = '{4'd6, {"delete", 16'h0}};
            2:  e = '{4'd6, {"append", 16'h0}};
            3:  e = '{4'd6, {"insert", 16'h0}};
            4:  e = '{4'd6, {"update", 16'h0}};
            5:  e = '{4'd4, {"read", 32'h0}};
            6:  e = '{4'd4, {"take", 32'h0}};
            7:  e = '{4'd7, {"bcreate", 8'h0}};
            8:  e = '{4'd7, {"bdelete", 8'h0}};
            9:  e = '{4'd7, {"bappend", 8'h0}};
            10: e = '{4'd7, {"binsert", 8'h0}};
            11: e = '{4'd7, {"bupdate", 8'h0}};
            12: e = '{4'd5, {"bread", 24'h0}};
            13: e = '{4'd5, {"btake", 24'h0}};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

FILE: src/query_token_scanner.sv
// Byte-stream tokenizer. One byte is taken per clock when the output side
// keeps up; each byte yields zero, one or two result transactions, which
// leave one per cycle, when out_stall is low, from a two-entry output queue;
// a byte with two results holds input until the second is popped. The first
// result shows the cycle after its byte: scanner state, keyword compare and
// times-ten accumulate settle ahead of the queue. No clearing after reset.
module query_token_scanner
    import qts_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [7:0]  text_char,
    output logic [9:0]  text_length,
    output logic [4:0]  keyword_index,
    output logic signed [31:0] number_value,
    output logic [4:0]  decimal_scale,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    scan_mode_t       mode_reg, mode_next;
    logic [TEXT_W-1:0] count_reg, count_next;
    logic [7:0]       pfx_reg [KEYWORD_CHARS];
    logic             pfx_we;
    logic [7:0]       pfx_wd;
    logic [32:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic [4:0]       frac_reg, frac_next;
    logic             op_reg, op_next;

    // output queue
    result_t q_reg [2];
    logic    ql_reg [2];
    logic [1:0] qn_reg;

    result_t r0, r1;
    logic [1:0] rn;
    logic accept, pop;

    logic [KEYWORD_CHARS*8-1:0] pfx_flat;
    kw_hit_t kwh;

    always_comb
    begin
        for (int i = 0; i < KEYWORD_CHARS; i++)
            pfx_flat[(KEYWORD_CHARS-1-i)*8 +: 8] = pfx_reg[i];
    end

    qts_keyword_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw
    (
        .prefix(pfx_flat),
        .count(count_reg),
        .hit(kwh)
    );

    assign pop = out_valid && !out_stall;
    // room for two after this cycle's pop
    assign in_stall = (qn_reg == 2'd2) || (qn_reg == 2'd1 && !pop);
    assign accept = in_valid && !in_stall;

    function automatic result_t mk(input logic [3:0] k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic result_t mk_err(input logic [1:0] e);
        result_t r;
        r = '0;
        r.kind = K_ERROR;
        r.err = e;
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [32:0] acc10(input logic [32:0] a, input logic [7:0] c);
        logic [36:0] v;
        v = {4'b0, a} * 37'd10 + 37'(c - 8'd48);
        return (v > 37'(ACC_SAT)) ? ACC_SAT : v[32:0];
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic restart;
        logic dec;
        logic [1:0] ovh;
        logic [32:0] lim;
        logic full;
        logic sgn;
        result_t fin;
        result_t sr;
        logic s_emit;
        c = in_byte;
        mode_next = mode_reg;
        count_next = count_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        frac_next = frac_reg;
        op_next = op_reg;
        pfx_we = 1'b0;
        pfx_wd = c;
        r0 = '0;
        r1 = '0;
        rn = 2'd0;
        restart = 1'b0;
        fin = '0;
        full = (count_reg >= TEXT_W'(MAX_TEXT_DEF));
        dec = (mode_reg == M_DECIMAL);
        sgn = (pfx_reg[0] == "+") || (pfx_reg[0] == "-");
        ovh = {1'b0, sgn} + {1'b0, dec};
        lim = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        sr = '0;
        s_emit = 1'b0;

        unique case (mode_reg)
            M_IDENT:
            begin
                if (is_letter(c) || is_digit(c))
                begin
                    if (full)
                    begin
                        r0 = mk_err(E_TOO_LONG);
                        rn = 2'd1;
                        mode_next = M_START;
                        count_next = '0;
                    end
                    else
                    begin
                        pfx_we = 1'b1;
                        count_next = count_reg + 1'b1;
                        r0 = mk(K_TEXT);
                        r0.ch = c;
                        rn = 2'd1;
                    end
                end
                else
                begin
                    if (kwh.hit)
                    begin
                        fin = mk(kwh.is_op ? K_OPCODE : K_TYPEKW);
                        fin.len = count_reg;
                        fin.kw = kwh.index;
                        if (kwh.is_op)
                            op_next = 1'b1;
                    end
                    else if (!op_reg)
                        fin = mk_err(E_NO_OPCODE);
                    else
                    begin
                        fin = mk(K_IDENT);
                        fin.len = count_reg;
                    end
                    restart = 1'b1;
                end
            end
            M_NUMBER, M_DECIMAL:
            begin
                if (is_digit(c) || (c == "." && !dec))
                begin
                    if (full)
                    begin
                        r0 = mk_err(E_TOO_LONG);
                        rn = 2'd1;
                        mode_next = M_START;
                        count_next = '0;
                        acc_next = '0;
                        neg_next = 1'b0;
                        frac_next = '0;
                    end
                    else
                    begin
                        pfx_we = (count_reg < TEXT_W'(KEYWORD_CHARS));
                        count_next = count_reg + 1'b1;
                        if (c == ".")
                            mode_next = M_DECIMAL;
                        else if (!dec)
                            acc_next = acc10(acc_reg, c);
                        else if (frac_reg == 5'd31)
                            acc_next = ACC_SAT;
                        else
                        begin
                            frac_next = frac_reg + 1'b1;
                            acc_next = acc10(acc_reg, c);
                        end
                    end
                end
                else
                begin
                    if (count_reg <= TEXT_W'(ovh) || acc_reg > lim)
                        fin = mk_err(E_BAD_NUMBER);
                    else
                    begin
                        fin = mk(dec ? K_DECIMAL : K_INT);
                        fin.val = neg_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
                        fin.scale = dec ? frac_reg : 5'd0;
                    end
                    restart = 1'b1;
                end
            end
            M_STRING:
            begin
                if (c == "\"")
                begin
                    if (!op_reg)
                        r0 = mk_err(E_NO_OPCODE);
                    else
                    begin
                        r0 = mk(K_STRING);
                        r0.len = count_reg;
                    end
                    rn = 2'd1;
                    mode_next = M_START;
                    count_next = '0;
                end
                else if (full)
                begin
                    r0 = mk_err(E_TOO_LONG);
                    rn = 2'd1;
                    mode_next = M_START;
                    count_next = '0;
                end
                else
                begin
                    pfx_we = (count_reg < TEXT_W'(KEYWORD_CHARS));
                    count_next = count_reg + 1'b1;
                    r0 = mk(K_TEXT);
                    r0.ch = c;
                    rn = 2'd1;
                end
            end
            default:
                restart = 1'b1;
        endcase

        if (restart)
        begin
            mode_next = M_START;
            count_next = '0;
            acc_next = '0;
            neg_next = 1'b0;
            frac_next = '0;
            pfx_we = 1'b0;
            case (c)
                " ", "\t", "\r", "\n": s_emit = 1'b0;
                ";": begin sr = mk(K_SEMI);   s_emit = 1'b1; end
                "[": begin sr = mk(K_LBRACK); s_emit = 1'b1; end
                "]": begin sr = mk(K_RBRACK); s_emit = 1'b1; end
                "{": begin sr = mk(K_LBRACE); s_emit = 1'b1; end
                "}": begin sr = mk(K_RBRACE); s_emit = 1'b1; end
                "(": begin sr = mk(K_LPAREN); s_emit = 1'b1; end
                ")": begin sr = mk(K_RPAREN); s_emit = 1'b1; end
                ",": begin sr = mk(K_COMMA);  s_emit = 1'b1; end
                "\"": mode_next = M_STRING;
                default:
                begin
                    if (is_letter(c))
                    begin
                        pfx_we = 1'b1;
                        count_next = TEXT_W'(1);
                        mode_next = M_IDENT;
                        sr = mk(K_TEXT);
                        sr.ch = c;
                        s_emit = 1'b1;
                    end
                    else if (is_digit(c) || c == "+" || c == "-")
                    begin
                        pfx_we = 1'b1;
                        count_next = TEXT_W'(1);
                        neg_next = (c == "-");
                        if (is_digit(c))
                            acc_next = 33'(c - 8'd48);
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        sr = mk_err(E_UNEXPECTED);
                        s_emit = 1'b1;
                    end
                end
            endcase
            // a finishing token comes first; start state adds at most one
            if (mode_reg == M_IDENT || mode_reg == M_NUMBER || mode_reg == M_DECIMAL)
            begin
                r0 = fin;
                r1 = sr;
                rn = s_emit ? 2'd2 : 2'd1;
            end
            else
            begin
                r0 = sr;
                rn = s_emit ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            count_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            frac_reg  <= '0;
            op_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            frac_reg  <= frac_next;
            op_reg    <= op_next;
        end
    end

    localparam int PFX_IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

    always_ff @(posedge clk)
    begin
        if (accept && pfx_we)
        begin
            if (mode_next == M_IDENT && mode_reg != M_IDENT)
                pfx_reg[0] <= pfx_wd;
            else if (mode_next == M_NUMBER && count_next == TEXT_W'(1))
                pfx_reg[0] <= pfx_wd;
            else if (count_reg < TEXT_W'(KEYWORD_CHARS))
                pfx_reg[count_reg[PFX_IW-1:0]] <= pfx_wd;
        end
    end

    // queue: entry 0 is the head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qn_reg <= 2'd0;
        else
            qn_reg <= qn_reg - {1'b0, pop} + (accept ? rn : 2'd0);
    end

    // input is taken only when the queue is empty after this cycle's pop
    always_ff @(posedge clk)
    begin
        if (accept && rn != 2'd0)
        begin
            q_reg[0]  <= r0;
            ql_reg[0] <= (rn == 2'd1);
            q_reg[1]  <= r1;
            ql_reg[1] <= 1'b1;
        end
        else if (pop)
        begin
            q_reg[0]  <= q_reg[1];
            ql_reg[0] <= ql_reg[1];
        end
    end

    assign out_valid     = (qn_reg != 2'd0);
    assign token_kind    = q_reg[0].kind;
    assign text_char     = q_reg[0].ch;
    assign text_length   = q_reg[0].len;
    assign keyword_index = q_reg[0].kw;
    assign number_value  = q_reg[0].val;
    assign decimal_scale = q_reg[0].scale;
    assign error_code    = q_reg[0].err;
    assign last_of_run   = ql_reg[0];

endmodule

FILE: src/qts_keyword_match.sv
module qts_keyword_match
    import qts_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
)
(
    input  logic [KEYWORD_CHARS*8-1:0] prefix,
    input  logic [TEXT_W-1:0]          count,
    output kw_hit_t                    hit
);

    logic [63:0] pfx;
    logic [N_TYPE-1:0] t_m;
    logic [N_OP-1:0]   o_m;

    // byte 0 of the token sits in the top byte
    always_comb
    begin
        pfx = '0;
        pfx[63 -: KEYWORD_CHARS*8] = prefix;
    end

    always_comb
    begin
        kw_entry_t e;
        logic [63:0] mask;
        for (int i = 0; i < N_TYPE; i++)
        begin
            e = type_kw(i);
            mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * int'(e.len)));
            t_m[i] = (count == TEXT_W'(e.len)) && (int'(e.len) <= KEYWORD_CHARS)
                     && ((pfx & mask) == e.txt);
        end
        for (int i = 0; i < N_OP; i++)
        begin
            e = op_kw(i);
            mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * int'(e.len)));
            o_m[i] = (count == TEXT_W'(e.len)) && (int'(e.len) <= KEYWORD_CHARS)
                     && ((pfx & mask) == e.txt);
        end
    end

    always_comb
    begin
        hit = '0;
        for (int i = N_OP - 1; i >= 0; i--)
        begin
            if (o_m[i])
            begin
                hit.hit = 1'b1;
                hit.is_op = 1'b1;
                hit.index = 5'(i);
            end
        end
        for (int i = N_TYPE - 1; i >= 0; i--)
        begin
            if (t_m[i])
            begin
                hit.hit = 1'b1;
                hit.is_op = 1'b0;
                hit.index = 5'(i);
            end
        end
    end

endmodule

FILE: bench/query_token_scanner_test.sv
`timescale 1ns / 1ps

module query_token_scanner_test;
    import qts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        result_t    r;
        logic       last;
    } token_t;

    typedef struct {
        logic [7:0] b;
        bit         chk;
        logic [3:0] kind;
        logic [1:0] err;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic [7:0]  text_char;
    logic [9:0]  text_length;
    logic [4:0]  keyword_index;
    logic signed [31:0] number_value;
    logic [4:0]  decimal_scale;
    logic [1:0]  error_code;
    logic        last_of_run;

    query_token_scanner u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .text_char(text_char), .text_length(text_length),
        .keyword_index(keyword_index), .number_value(number_value),
        .decimal_scale(decimal_scale), .error_code(error_code),
        .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // tokenizer shadow state
    scan_mode_t  sh_mode;
    int          sh_count;
    logic [7:0]  sh_prefix [KEYWORD_CHARS_DEF];
    logic [63:0] sh_mag;
    bit          sh_neg;
    int          sh_frac;
    bit          sh_opseen;
    result_t     step_res [2];
    int          step_n;

    token_t      pending_tokens [$];
    logic [7:0]  byte_stream [$];
    dir_row_t    dir_rows [$];
    int          n_sent;
    int          n_errors;
    int          cycles;
    bit          in_taken;

    string type_names [27] = '{"struct", "union", "enum", "u8", "u16", "u32", "u64", "i8",
        "i16", "i32", "i64", "f16", "f32", "f64", "f128", "cf32", "cf64", "cf128", "cf256",
        "ci16", "ci32", "ci64", "ci128", "cu16", "cu32", "cu64", "cu128"};
    string op_names [14] = '{"create", "delete", "append", "insert", "update", "read",
        "take", "bcreate", "bdelete", "bappend", "binsert", "bupdate", "bread", "btake"};

    task automatic flag(string what);
        if (n_errors < 30)
            $display("MISMATCH @%0d: %s", cycles, what);
        n_errors++;
    endtask

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic emit(logic [3:0] kind, logic [7:0] ch, logic [9:0] len, logic [4:0] kw,
                        logic [31:0] val, logic [4:0] scale, logic [1:0] err);
        result_t r;
        if (step_n < 2)
        begin
            r.kind = kind; r.ch = ch; r.len = len; r.kw = kw;
            r.val = val; r.scale = scale; r.err = err;
            step_res[step_n] = r;
            step_n++;
        end
    endtask

    task automatic go_idle();
        sh_mode = M_START;
        sh_count = 0;
        sh_mag = '0;
        sh_neg = 1'b0;
        sh_frac = 0;
    endtask

    task automatic abort_token(logic [1:0] code);
        emit(K_ERROR, 0, 0, 0, 0, 0, code);
        go_idle();
    endtask

    task automatic append_text(logic [7:0] c, output bit ok);
        ok = 1'b0;
        if (sh_count >= MAX_TEXT_DEF)
            abort_token(E_TOO_LONG);
        else
        begin
            if (sh_count < KEYWORD_CHARS_DEF)
                sh_prefix[sh_count] = c;
            sh_count++;
            ok = 1'b1;
        end
    endtask

    function automatic bit word_match(string s);
        if (sh_count != s.len() || s.len() > KEYWORD_CHARS_DEF)
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (sh_prefix[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic close_word();
        for (int i = 0; i < 27; i++)
            if (word_match(type_names[i]))
            begin
                emit(K_TYPEKW, 0, 10'(sh_count), 5'(i), 0, 0, 0);
                go_idle();
                return;
            end
        for (int i = 0; i < 14; i++)
            if (word_match(op_names[i]))
            begin
                sh_opseen = 1'b1;
                emit(K_OPCODE, 0, 10'(sh_count), 5'(i), 0, 0, 0);
                go_idle();
                return;
            end
        if (!sh_opseen)
            abort_token(E_NO_OPCODE);
        else
        begin
            emit(K_IDENT, 0, 10'(sh_count), 0, 0, 0, 0);
            go_idle();
        end
    endtask

    task automatic close_number(bit dec);
        int          overhead;
        logic [63:0] lim;
        logic [63:0] v;
        overhead = ((sh_prefix[0] == "+" || sh_prefix[0] == "-") ? 1 : 0) + (dec ? 1 : 0);
        lim = sh_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (sh_count <= overhead || sh_mag > lim)
            abort_token(E_BAD_NUMBER);
        else
        begin
            v = sh_neg ? (64'd0 - sh_mag) : sh_mag;
            emit(dec ? K_DECIMAL : K_INT, 0, 0, 0, v[31:0], 5'(dec ? sh_frac : 0), 0);
            go_idle();
        end
    endtask

    task automatic add_digit(logic [7:0] c);
        logic [63:0] v;
        v = sh_mag * 10 + 64'(c - "0");
        sh_mag = (v > 64'h1_0000_0000) ? 64'h1_0000_0000 : v;
    endtask

    task automatic fresh_byte(logic [7:0] c);
        case (c)
            " ", 8'h09, 8'h0D, 8'h0A: return;
            ";": begin emit(K_SEMI, 0, 0, 0, 0, 0, 0); return; end
            "[": begin emit(K_LBRACK, 0, 0, 0, 0, 0, 0); return; end
            "]": begin emit(K_RBRACK, 0, 0, 0, 0, 0, 0); return; end
            "{": begin emit(K_LBRACE, 0, 0, 0, 0, 0, 0); return; end
            "}": begin emit(K_RBRACE, 0, 0, 0, 0, 0, 0); return; end
            "(": begin emit(K_LPAREN, 0, 0, 0, 0, 0, 0); return; end
            ")": begin emit(K_RPAREN, 0, 0, 0, 0, 0, 0); return; end
            ",": begin emit(K_COMMA, 0, 0, 0, 0, 0, 0); return; end
            "\"":
            begin
                go_idle();
                sh_mode = M_STRING;
                return;
            end
            default: ;
        endcase
        go_idle();
        if (is_letter(c))
        begin
            sh_prefix[0] = c;
            sh_count = 1;
            sh_mode = M_IDENT;
            emit(K_TEXT, c, 0, 0, 0, 0, 0);
        end
        else if (is_digit(c) || c == "+" || c == "-")
        begin
            sh_prefix[0] = c;
            sh_count = 1;
            sh_neg = (c == "-");
            if (is_digit(c))
                sh_mag = 64'(c - "0");
            sh_mode = M_NUMBER;
        end
        else
            abort_token(E_UNEXPECTED);
    endtask

    task automatic scan_byte(logic [7:0] c);
        bit     ok;
        token_t t;
        step_n = 0;
        case (sh_mode)
            M_IDENT:
                if (is_letter(c) || is_digit(c))
                begin
                    append_text(c, ok);
                    if (ok)
                        emit(K_TEXT, c, 0, 0, 0, 0, 0);
                end
                else
                begin
                    close_word();
                    fresh_byte(c);
                end
            M_NUMBER:
                if (is_digit(c))
                begin
                    append_text(c, ok);
                    if (ok)
                        add_digit(c);
                end
                else if (c == ".")
                begin
                    append_text(c, ok);
                    if (ok)
                        sh_mode = M_DECIMAL;
                end
                else
                begin
                    close_number(1'b0);
                    fresh_byte(c);
                end
            M_DECIMAL:
                if (is_digit(c))
                begin
                    append_text(c, ok);
                    if (ok)
                    begin
                        if (sh_frac >= 31)
                            sh_mag = 64'h1_0000_0000;
                        else
                        begin
                            sh_frac++;
                            add_digit(c);
                        end
                    end
                end
                else
                begin
                    close_number(1'b1);
                    fresh_byte(c);
                end
            M_STRING:
                if (c == "\"")
                begin
                    if (!sh_opseen)
                        abort_token(E_NO_OPCODE);
                    else
                    begin
                        emit(K_STRING, 0, 10'(sh_count), 0, 0, 0, 0);
                        go_idle();
                    end
                end
                else
                begin
                    append_text(c, ok);
                    if (ok)
                        emit(K_TEXT, c, 0, 0, 0, 0, 0);
                end
            default: fresh_byte(c);
        endcase
        for (int k = 0; k < step_n; k++)
        begin
            t.r = step_res[k];
            t.last = (k == step_n - 1);
            pending_tokens.push_back(t);
        end
    endtask

    // stimulus builders
    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            byte_stream.push_back(s[i]);
    endtask

    function automatic string digit_run(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic logic [7:0] separator();
        case ($urandom_range(0, 11))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0D;
            3: return ";";
            4: return ",";
            5: return ")";
            6: return "]";
            7: return "}";
            8: return "\"";
            default: return " ";
        endcase
    endfunction

    task automatic add_random_token();
        int          n;
        longint      v;
        string       s;
        string       punct;
        logic [7:0]  c;
        punct = ";[]{}(),";
        case ($urandom_range(0, 19))
            0, 1: put_str(type_names[$urandom_range(0, 26)]);
            2, 3: put_str(op_names[$urandom_range(0, 13)]);
            4, 5, 6:
            begin
                s = "";
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 61));
                    if (i == 0 || c < 26)
                        c = (c % 26) + (($urandom_range(0, 1) != 0) ? "a" : "A");
                    else if (c < 36)
                        c = c - 26 + "0";
                    else
                        c = c - 36 + "a";
                    s = {s, string'(c)};
                end
                put_str(s);
            end
            7, 8:
            begin
                byte_stream.push_back("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    byte_stream.push_back(c == "\"" ? 8'h41 : c);
                end
                byte_stream.push_back("\"");
            end
            9, 10, 11:
            begin
                case ($urandom_range(0, 7))
                    0: v = 64'sd2147483647;
                    1: v = 64'sd2147483648;
                    2: v = -64'sd2147483648;
                    3: v = -64'sd2147483649;
                    4: v = $signed(32'($urandom()));
                    5: v = longint'($urandom()) * 40;
                    default: v = $urandom_range(0, 999);
                endcase
                if (v >= 0 && $urandom_range(0, 3) == 0)
                    put_str({"+", $sformatf("%0d", v)});
                else
                    put_str($sformatf("%0d", v));
            end
            12, 13:
            begin
                n = $urandom_range(0, 3);
                s = ($urandom_range(0, 2) == 0) ? "-" : (($urandom_range(0, 4) == 0) ? "+" : "");
                s = {s, digit_run(n == 0 ? 0 : $urandom_range(1, 5)), "."};
                case ($urandom_range(0, 9))
                    0: s = {s, digit_run($urandom_range(30, 33))};
                    1: s = {s, digit_run($urandom_range(8, 12))};
                    default: s = {s, digit_run($urandom_range(0, 4))};
                endcase
                if ($urandom_range(0, 9) == 0)
                    s = {s, "."};
                put_str(s);
            end
            14, 15: byte_stream.push_back(punct[$urandom_range(0, 7)]);
            16: put_str($urandom_range(0, 1) ? "+" : "-");
            default:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    byte_stream.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        byte_stream.push_back(separator());
    endtask

    task automatic add_row(logic [7:0] b, bit chk = 0, logic [3:0] kind = K_TEXT,
                           logic [1:0] err = E_UNEXPECTED);
        dir_row_t r;
        r.b = b; r.chk = chk; r.kind = kind; r.err = err;
        dir_rows.push_back(r);
    endtask

    // acceptance and result checking
    always @(posedge clk)
    begin
        token_t t;
        cycles <= cycles + 1;
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            scan_byte(in_byte);
            if (n_sent < dir_rows.size() && dir_rows[n_sent].chk)
            begin
                if (step_n == 0 || step_res[0].kind != dir_rows[n_sent].kind
                    || step_res[0].err != dir_rows[n_sent].err)
                    flag($sformatf("directed byte %0d: table kind %0d err %0d disagrees",
                                   n_sent, dir_rows[n_sent].kind, dir_rows[n_sent].err));
            end
            n_sent = n_sent + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
                flag($sformatf("unexpected transaction kind %0d", token_kind));
            else
            begin
                t = pending_tokens.pop_front();
                if (token_kind !== t.r.kind)
                    flag($sformatf("kind %0d, want %0d", token_kind, t.r.kind));
                if (text_char !== t.r.ch)
                    flag($sformatf("text_char %h, want %h", text_char, t.r.ch));
                if (text_length !== t.r.len)
                    flag($sformatf("text_length %0d, want %0d", text_length, t.r.len));
                if (keyword_index !== t.r.kw)
                    flag($sformatf("keyword_index %0d, want %0d", keyword_index, t.r.kw));
                if (number_value !== t.r.val)
                    flag($sformatf("number_value %h, want %h", number_value, t.r.val));
                if (decimal_scale !== t.r.scale)
                    flag($sformatf("decimal_scale %0d, want %0d", decimal_scale, t.r.scale));
                if (error_code !== t.r.err)
                    flag($sformatf("error_code %0d, want %0d", error_code, t.r.err));
                if (last_of_run !== t.last)
                    flag($sformatf("last_of_run %b, want %b", last_of_run, t.last));
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive at the falling edge; a presented byte stays until accepted
    always @(negedge clk)
    begin
        int tx_idle;
        int rx_idle;
        int total;
        total = byte_stream.size();
        if (n_sent < total / 3)
        begin
            tx_idle = 36; rx_idle = 61;
        end
        else if (n_sent < (2 * total) / 3)
        begin
            tx_idle = 61; rx_idle = 36;
        end
        else
        begin
            tx_idle = 0; rx_idle = 0;
        end
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < rx_idle);
            if (!in_valid || in_taken)
            begin
                if (n_sent < total && $urandom_range(0, 99) >= tx_idle)
                begin
                    in_valid <= 1'b1;
                    in_byte <= byte_stream[n_sent];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    initial
    begin
        int guard;
        int ovf;
        string cu;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        out_stall = 1'b0;
        n_sent = 0;
        n_errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        sh_opseen = 1'b0;
        for (int i = 0; i < KEYWORD_CHARS_DEF; i++)
            sh_prefix[i] = '0;
        go_idle();

        // identifier and string before any opcode, then opcode, punctuation,
        // sign with no digit, unexpected bytes, trailing-dot decimal
        add_row("x", 1, K_TEXT);
        add_row(" ", 1, K_ERROR, E_NO_OPCODE);
        add_row("\"");
        add_row("q", 1, K_TEXT);
        add_row("\"", 1, K_ERROR, E_NO_OPCODE);
        cu = "bread";
        for (int i = 0; i < cu.len(); i++)
            add_row(cu[i]);
        add_row(";");
        add_row("[", 1, K_LBRACK);
        add_row("]", 1, K_RBRACK);
        add_row("{", 1, K_LBRACE);
        add_row("}", 1, K_RBRACE);
        add_row("(", 1, K_LPAREN);
        add_row(")", 1, K_RPAREN);
        add_row(",", 1, K_COMMA);
        add_row("-");
        add_row(".");
        add_row(" ", 1, K_ERROR, E_BAD_NUMBER);
        add_row(8'h00, 1, K_ERROR, E_UNEXPECTED);
        add_row(8'hFF, 1, K_ERROR, E_UNEXPECTED);
        add_row("9");
        add_row(".");
        add_row(";", 1, K_DECIMAL);
        foreach (dir_rows[i])
            byte_stream.push_back(dir_rows[i].b);

        // random part, with one overflow run of an identifier, a string or a number
        ovf = $urandom_range(0, 2);
        for (int i = 0; i < 100; i++)
        begin
            add_random_token();
            if (i == 50)
            begin
                case (ovf)
                    0:
                    begin
                        for (int j = 0; j < 515; j++)
                            byte_stream.push_back("k");
                        byte_stream.push_back(" ");
                    end
                    1:
                    begin
                        byte_stream.push_back("\"");
                        for (int j = 0; j < 514; j++)
                            byte_stream.push_back(8'($urandom_range(0, 33)));
                        byte_stream.push_back("\"");
                    end
                    default:
                    begin
                        put_str({"1", digit_run(513)});
                        byte_stream.push_back(" ");
                    end
                endcase
            end
        end
        byte_stream.push_back(" ");

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_sent == byte_stream.size());
        wait (pending_tokens.size() == 0);
        guard = 0;
        while (guard < 20)
        begin
            @(posedge clk);
            guard++;
        end
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/qts_pkg.sv
src/qts_keyword_match.sv
src/query_token_scanner.sv
bench/query_token_scanner_test.sv
